[src/b64d_pkg.sv]
// ---------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character map for the base64url decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [5:0] value;
        logic       bad;
        logic       last;
    } class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       string_done;
        logic       failed;
    } res_t;

    function automatic class_t classify(input logic [7:0] c, input logic fin);
        class_t w;
        w.last  = fin;
        w.bad   = 1'b0;
        w.value = 6'd0;
        case (c) inside
            ["A":"Z"]: w.value = 6'(c - 8'h41);
            ["a":"z"]: w.value = 6'(c - 8'h61 + 8'd26);
            ["0":"9"]: w.value = 6'(c - 8'h30 + 8'd52);
            "-":       w.value = 6'd62;
            "_":       w.value = 6'd63;
            default:   w.bad   = 1'b1;
        endcase
        return w;
    endfunction

endpackage

[src/b64d_front.sv]
// ---------------------------------------------------------------------------
// b64d_front
// Classifies each incoming character into its 6-bit value and a bad mark.
// ---------------------------------------------------------------------------
module b64d_front
(
    input  logic [7:0]      symbol,
    input  logic            last,
    output b64d_pkg::class_t word
);

    assign word = b64d_pkg::classify(symbol, last);

endmodule

[src/b64d_queue.sv]
// ---------------------------------------------------------------------------
// b64d_queue
// Short queue of classified words between the front and the back.
// ---------------------------------------------------------------------------
module b64d_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  b64d_pkg::class_t wr_word,
    input  logic             rd_en,
    output b64d_pkg::class_t rd_word,
    output logic             q_full,
    output logic             q_empty
);

    b64d_pkg::class_t              mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QAW-1:0]      wr_ptr_reg;
    logic [b64d_pkg::QAW-1:0]      rd_ptr_reg;
    logic [b64d_pkg::QAW:0]        count_reg;
    logic [b64d_pkg::QAW:0]        count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign q_full  = (count_reg == (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_word = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

[src/b64d_back.sv]
// ---------------------------------------------------------------------------
// b64d_back
// Assembles bytes from 6-bit values, tracks errors and holds the result.
// ---------------------------------------------------------------------------
module b64d_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  b64d_pkg::class_t word,
    output logic             q_pop,
    input  logic             pop,
    output logic             res_empty,
    output b64d_pkg::res_t   res
);

    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic [7:0]     carry_reg;
    logic [7:0]     carry_next;
    logic           err_reg;
    logic           err_next;
    logic           out_valid_reg;
    b64d_pkg::res_t res_reg;
    b64d_pkg::res_t res_next;
    logic [5:0]     v;
    logic [7:0]     byte_val;
    logic           fire;

    assign fire      = !q_empty && (!out_valid_reg || pop);
    assign q_pop     = fire;
    assign res_empty = !out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        err_next = err_reg || word.bad;
        v        = word.bad ? 6'd0 : word.value;
        byte_val = 8'd0;
        case (phase_reg)
            2'd0:
            begin
                carry_next = {v, 2'b00};
            end
            2'd1:
            begin
                byte_val   = carry_reg | {4'd0, v[5:4]};
                carry_next = {v[3:0], 4'd0};
            end
            2'd2:
            begin
                byte_val   = carry_reg | {2'd0, v[5:2]};
                carry_next = {v[1:0], 6'd0};
            end
            default:
            begin
                byte_val   = carry_reg | {2'd0, v};
                carry_next = 8'd0;
            end
        endcase
        res_next.byte_valid  = !err_next && (phase_reg != 2'd0);
        res_next.data_byte   = res_next.byte_valid ? byte_val : 8'd0;
        res_next.string_done = word.last;
        res_next.failed      = word.last && (err_next || phase_reg == 2'd0);
        phase_next           = phase_reg + 1'b1;
        if (word.last)
        begin
            phase_next = 2'd0;
            carry_next = 8'd0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            carry_reg     <= 8'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg     <= phase_next;
                carry_reg     <= carry_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[src/base64url_stream_decoder_unit.sv]
// ---------------------------------------------------------------------------
// base64url_stream_decoder_unit
// Unpadded base64url decoder, one character per word in, one result out.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle while results are popped, set by the
// phase/carry register loop in the back end; a four-entry queue lets front
// and back stall apart.
// Reset: clears phase, carry and error state and empties the queue and the result register.
// ---------------------------------------------------------------------------
module base64url_stream_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] symbol,
    input  logic       last,
    input  logic       push,
    output logic       full,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       string_done,
    output logic       failed,
    output logic       empty,
    input  logic       pop
);

    b64d_pkg::class_t in_word;
    b64d_pkg::class_t q_word;
    b64d_pkg::res_t   res;
    logic             q_empty;
    logic             q_pop;

    b64d_front u_front
    (
        .symbol (symbol),
        .last   (last),
        .word   (in_word)
    );

    b64d_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_word (in_word),
        .rd_en   (q_pop),
        .rd_word (q_word),
        .q_full  (full),
        .q_empty (q_empty)
    );

    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .word      (q_word),
        .q_pop     (q_pop),
        .pop       (pop),
        .res_empty (empty),
        .res       (res)
    );

    assign data_byte   = res.data_byte;
    assign byte_valid  = res.byte_valid;
    assign string_done = res.string_done;
    assign failed      = res.failed;

    a_fail_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!failed || string_done))
        else $error("failed without string_done");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (data_byte == 8'd0))
        else $error("data_byte nonzero without byte_valid");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && q_empty) |=> !q_empty)
        else $error("accepted word lost from queue");

    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && empty) |-> q_pop)
        else $error("back end idle with work waiting");

endmodule
